// ===== src/bnt_pkg.sv =====
`timescale 1ns / 1ps
package bnt_pkg;

   // Tone counter width
   localparam int PERIOD_BITS = 16;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN = PERIOD_BITS'(2);

   // Field widths
   localparam int TICK_RATE_BITS = 24;
   localparam int FREQ_BITS      = 16;
   localparam int DUR_BITS       = 16;
   localparam int TPMS_BITS      = 16;
   localparam int GAP_BITS       = 8;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 24;

   // Configuration reset values
   localparam logic [TICK_RATE_BITS-1:0] TICK_RATE_RESET = 24'd1000000;
   localparam logic [TPMS_BITS-1:0]      TPMS_RESET      = 16'd1000;
   localparam logic [GAP_BITS-1:0]       GAP_RESET       = 8'd20;
   localparam logic [DUR_BITS-1:0]       GAP_MIN_RESET   = 16'd30;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_RATE = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TPMS      = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP       = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAP_MIN   = 8'd3;

   // Command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;
   localparam int QUEUE_CNT_BITS  = 2;

   // Divider: one quotient bit per step
   localparam int DIV_STEPS    = TICK_RATE_BITS;
   localparam int DIV_CNT_BITS = 5;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

   typedef struct packed {
      logic                 cmd;
      logic [FREQ_BITS-1:0] tone_hz;
      logic [DUR_BITS-1:0]  note_ms;
   } req_word_type;

   typedef struct packed {
      logic pin_level;
      logic playing;
      logic note_done;
   } rsp_word_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_REST,
      KIND_NOTE
   } item_kind_type;

   typedef struct packed {
      item_kind_type        kind;
      logic [FREQ_BITS-1:0] tone_hz;
      logic [DUR_BITS-1:0]  note_ms;
   } queue_entry_type;

   typedef struct packed {
      logic                      start;
      logic [TICK_RATE_BITS-1:0] dividend;
      logic [FREQ_BITS-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic [TICK_RATE_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SOUND,
      PH_GAP
   } play_phase_type;

   typedef enum logic {
      BK_IDLE,
      BK_DIV
   } back_state_type;

endpackage

// ===== src/bnt_front.sv =====
`timescale 1ns / 1ps
module bnt_front import bnt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_word_type    req_data,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_pop
);

   queue_entry_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]     count_ff, count_in;
   queue_entry_type               classified;
   logic                          push;
   logic                          pop;

   assign req_stall = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = entry_ff[rd_ptr_ff];

   // Classify the incoming word
   always_comb begin
      classified.tone_hz = req_data.tone_hz;
      classified.note_ms = req_data.note_ms;
      if (req_data.cmd == CMD_TICK) begin
         classified.kind = KIND_TICK;
      end else if (req_data.tone_hz == '0) begin
         classified.kind = KIND_REST;
      end else begin
         classified.kind = KIND_NOTE;
      end
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== src/bnt_divider.sv =====
`timescale 1ns / 1ps
module bnt_divider import bnt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [FREQ_BITS-1:0]      rem_ff, rem_in;
   logic [TICK_RATE_BITS-1:0] quo_ff, quo_in;
   logic [FREQ_BITS-1:0]      div_ff, div_in;
   logic [FREQ_BITS:0]        trial;
   logic [FREQ_BITS:0]        diff;
   logic                      fits;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // One restoring step: shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[TICK_RATE_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
         quo_in = {quo_ff[TICK_RATE_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== src/bnt_back.sv =====
`timescale 1ns / 1ps
module bnt_back import bnt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      q_valid,
   input  queue_entry_type           q_entry,
   output logic                      q_pop,
   output div_req_type               div_req,
   input  div_rsp_type               div_rsp,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_data
);

   // Configuration
   logic [TICK_RATE_BITS-1:0] tick_rate_ff;
   logic [TPMS_BITS-1:0]      tpms_ff;
   logic [GAP_BITS-1:0]       gap_ff;
   logic [DUR_BITS-1:0]       gap_min_ff;

   // Player state
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PERIOD_BITS-1:0] compare_ff, compare_in;
   logic [PERIOD_BITS-1:0] count_ff, count_in;
   logic [TPMS_BITS-1:0]   prescale_ff, prescale_in;
   logic [DUR_BITS-1:0]    ms_left_ff, ms_left_in;
   logic [GAP_BITS-1:0]    gap_left_ff, gap_left_in;
   play_phase_type         phase_ff, phase_in;
   back_state_type         state_ff, state_in;
   logic [DUR_BITS-1:0]    dur_ff, dur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_data_ff, rsp_data_in;

   logic                   slot_free;
   logic                   do_load;
   logic                   load_tone;
   logic [DUR_BITS-1:0]    load_dur;
   logic                   with_gap;
   logic [DUR_BITS-1:0]    sound;
   logic [PERIOD_BITS:0]   count_next;
   logic [TPMS_BITS:0]     prescale_next;
   logic [DUR_BITS-1:0]    ms_dec;
   logic [GAP_BITS-1:0]    gap_dec;
   logic                   finish;
   logic                   done;
   logic [PERIOD_BITS-1:0] period_clamped;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == BK_IDLE) && q_valid && slot_free;

   assign div_req.start    = q_pop && (q_entry.kind == KIND_NOTE);
   assign div_req.dividend = tick_rate_ff;
   assign div_req.divisor  = q_entry.tone_hz;

   // Clamp the quotient to the period range
   always_comb begin
      if (div_rsp.quotient < TICK_RATE_BITS'(PERIOD_MIN)) begin
         period_clamped = PERIOD_MIN;
      end else if ({{PERIOD_BITS{1'b0}}, div_rsp.quotient} >
                   {{TICK_RATE_BITS{1'b0}}, PERIOD_MAX}) begin
         period_clamped = PERIOD_MAX;
      end else begin
         period_clamped = PERIOD_BITS'(div_rsp.quotient);
      end
   end

   always_comb begin
      period_in    = period_ff;
      compare_in   = compare_ff;
      count_in     = count_ff;
      prescale_in  = prescale_ff;
      ms_left_in   = ms_left_ff;
      gap_left_in  = gap_left_ff;
      phase_in     = phase_ff;
      state_in     = state_ff;
      dur_in       = dur_ff;
      finish       = 1'b0;
      done         = 1'b0;
      do_load      = 1'b0;
      load_tone    = 1'b0;
      load_dur     = dur_ff;
      with_gap     = 1'b0;
      sound        = '0;
      ms_dec       = ms_left_ff;
      gap_dec      = gap_left_ff;
      count_next   = {1'b0, count_ff} + 1'b1;
      prescale_next = {1'b0, prescale_ff} + 1'b1;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               unique case (q_entry.kind)
                  KIND_TICK: begin
                     finish = 1'b1;
                     // Advance the tone counter, wrapping at the period
                     count_in = (count_next >= {1'b0, period_ff}) ? '0
                                                                  : count_next[PERIOD_BITS-1:0];
                     if (phase_ff != PH_IDLE) begin
                        if (prescale_next < {1'b0, tpms_ff}) begin
                           prescale_in = prescale_next[TPMS_BITS-1:0];
                        end else begin
                           prescale_in = '0;
                           if (phase_ff == PH_SOUND) begin
                              if (ms_left_ff != '0) begin
                                 ms_dec = ms_left_ff - 1'b1;
                              end
                              ms_left_in = ms_dec;
                              if (ms_dec == '0) begin
                                 compare_in = '0;
                                 if (gap_left_ff != '0) begin
                                    phase_in = PH_GAP;
                                 end else begin
                                    phase_in = PH_IDLE;
                                    done     = 1'b1;
                                 end
                              end
                           end else begin
                              if (gap_left_ff != '0) begin
                                 gap_dec = gap_left_ff - 1'b1;
                              end
                              gap_left_in = gap_dec;
                              if (gap_dec == '0) begin
                                 compare_in = '0;
                                 phase_in   = PH_IDLE;
                                 done       = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  KIND_REST: begin
                     finish   = 1'b1;
                     do_load  = 1'b1;
                     load_dur = q_entry.note_ms;
                  end
                  KIND_NOTE: begin
                     dur_in   = q_entry.note_ms;
                     state_in = BK_DIV;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         BK_DIV: begin
            if (div_rsp.done) begin
               finish    = 1'b1;
               do_load   = 1'b1;
               load_tone = 1'b1;
               load_dur  = dur_ff;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Start a note or rest
      if (do_load) begin
         if (load_tone) begin
            period_in  = period_clamped;
            compare_in = period_clamped >> 1;
            count_in   = '0;
         end else begin
            compare_in = '0;
         end
         prescale_in = '0;
         with_gap    = (load_dur > gap_min_ff) && load_tone;
         sound       = load_dur;
         gap_left_in = '0;
         if (with_gap) begin
            sound       = (load_dur > DUR_BITS'(gap_ff)) ? load_dur - DUR_BITS'(gap_ff) : '0;
            gap_left_in = gap_ff;
         end
         ms_left_in = sound;
         if (sound != '0) begin
            phase_in = PH_SOUND;
         end else begin
            compare_in = '0;
            if (gap_left_in != '0) begin
               phase_in = PH_GAP;
            end else begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
      end
   end

   // Hold, drop or load the result word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.pin_level = (count_in < compare_in);
         rsp_data_in.playing   = (phase_in != PH_IDLE);
         rsp_data_in.note_done = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= '0;
         compare_ff   <= '0;
         count_ff     <= '0;
         prescale_ff  <= '0;
         ms_left_ff   <= '0;
         gap_left_ff  <= '0;
         phase_ff     <= PH_IDLE;
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         compare_ff   <= compare_in;
         count_ff     <= count_in;
         prescale_ff  <= prescale_in;
         ms_left_ff   <= ms_left_in;
         gap_left_ff  <= gap_left_in;
         phase_ff     <= phase_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff      <= dur_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
         tpms_ff      <= TPMS_RESET;
         gap_ff       <= GAP_RESET;
         gap_min_ff   <= GAP_MIN_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TICK_RATE) begin
            tick_rate_ff <= csr_data[TICK_RATE_BITS-1:0];
         end else if (csr_index == CSR_TPMS) begin
            tpms_ff <= csr_data[TPMS_BITS-1:0];
         end else if (csr_index == CSR_GAP) begin
            gap_ff <= csr_data[GAP_BITS-1:0];
         end else if (csr_index == CSR_GAP_MIN) begin
            gap_min_ff <= csr_data[DUR_BITS-1:0];
         end
      end
   end

endmodule

// ===== src/buzzer_note_tone_player.sv =====
`timescale 1ns / 1ps
// Flow: a tick or rest word is stored in the queue, popped, and its result registered; a
//   sounded note load also waits in between for the 24-step radix-2 period divider.
// Throughput: one tick or rest word per cycle while the result is not stalled; a note
//   load holds the back end, which pops no new word until the divider is done.
// Reset (synchronous, active high): queue and result cleared, player idle, counters
//   zero, configuration back to its defaults; no clearing pass.
module buzzer_note_tone_player import bnt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   // Registers are always writable
   assign csr_ready = 1'b1;

   bnt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   bnt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bnt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== bench/buzzer_note_tone_player_tb.sv =====
`timescale 1ns / 1ps
module buzzer_note_tone_player_tb;
   import bnt_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int HOLD_CYCLES     = 200;
   localparam int HOLD_WORDS      = 40;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 235;
   localparam int TAIL_CYCLES     = 40;
   localparam int MAX_PRINTED     = 200;

   // One line of the directed table: a register write or a run of equal words
   typedef struct {
      bit                        is_reg;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  reg_value;
      req_word_type              word;
      int                        repeats;
      bit                        typed;
      rsp_word_type              want;
   } stim_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Player model state and its copy of the registers
   logic [TICK_RATE_BITS-1:0] cfg_tick_rate;
   logic [TPMS_BITS-1:0]      cfg_tpms;
   logic [GAP_BITS-1:0]       cfg_gap;
   logic [DUR_BITS-1:0]       cfg_gap_min;
   logic [PERIOD_BITS-1:0]    pred_period;
   logic [PERIOD_BITS-1:0]    pred_compare;
   logic [PERIOD_BITS-1:0]    pred_count;
   logic [TPMS_BITS-1:0]      pred_prescale;
   logic [DUR_BITS-1:0]       pred_ms_left;
   logic [GAP_BITS-1:0]       pred_gap_left;
   play_phase_type            pred_phase;

   rsp_word_type expected_words[$];
   stim_row_type directed_rows[$];

   // Stimulus control shared between processes
   bit           req_idle_en = 1'b1;
   bit           rsp_idle_en = 1'b1;
   bit           hold_rsp_request = 1'b0;
   bit           row_typed = 1'b0;
   rsp_word_type row_want = '0;
   int           hold_left = 0;
   int           stall_left = 0;

   int           error_count = 0;
   int           words_accepted = 0;
   int           results_seen = 0;
   int           notes_ended = 0;
   rsp_word_type predicted;
   rsp_word_type want_w;

   buzzer_note_tone_player u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Advance the player by one word and return the levels it shows afterwards
   function automatic rsp_word_type advance_player(input req_word_type w);
      rsp_word_type            r;
      logic [TICK_RATE_BITS-1:0] quot;
      logic [PERIOD_BITS:0]    cnt_next;
      int unsigned             sound_ms;
      int unsigned             pre_next;
      logic                    with_gap;
      logic                    done;
      done = 1'b0;
      if (w.cmd == CMD_LOAD) begin
         // Load: divide for the period unless this is a rest
         if (w.tone_hz == '0) begin
            pred_compare = '0;
         end else begin
            quot = cfg_tick_rate / w.tone_hz;
            if (quot < PERIOD_MIN) begin
               pred_period = PERIOD_MIN;
            end else if (quot > PERIOD_MAX) begin
               pred_period = PERIOD_MAX;
            end else begin
               pred_period = quot[PERIOD_BITS-1:0];
            end
            pred_compare = pred_period >> 1;
            pred_count = '0;
         end
         pred_prescale = '0;
         with_gap = (w.note_ms > cfg_gap_min) && (w.tone_hz != '0);
         sound_ms = w.note_ms;
         pred_gap_left = '0;
         if (with_gap) begin
            sound_ms = (w.note_ms > cfg_gap) ? w.note_ms - cfg_gap : 0;
            pred_gap_left = cfg_gap;
         end
         pred_ms_left = sound_ms[DUR_BITS-1:0];
         if (sound_ms != 0) begin
            pred_phase = PH_SOUND;
         end else begin
            pred_compare = '0;
            if (pred_gap_left != '0) begin
               pred_phase = PH_GAP;
            end else begin
               pred_phase = PH_IDLE;
               done = 1'b1;
            end
         end
      end else begin
         // Tick: wrap the tone counter, then run the millisecond prescaler
         cnt_next = {1'b0, pred_count} + 1'b1;
         pred_count = (cnt_next >= {1'b0, pred_period}) ? '0 : cnt_next[PERIOD_BITS-1:0];
         if (pred_phase != PH_IDLE) begin
            pre_next = pred_prescale + 1;
            if (pre_next < cfg_tpms) begin
               pred_prescale = pre_next[TPMS_BITS-1:0];
            end else begin
               pred_prescale = '0;
               if (pred_phase == PH_SOUND) begin
                  if (pred_ms_left != '0) pred_ms_left = pred_ms_left - 1'b1;
                  if (pred_ms_left == '0) begin
                     pred_compare = '0;
                     if (pred_gap_left != '0) begin
                        pred_phase = PH_GAP;
                     end else begin
                        pred_phase = PH_IDLE;
                        done = 1'b1;
                     end
                  end
               end else begin
                  if (pred_gap_left != '0) pred_gap_left = pred_gap_left - 1'b1;
                  if (pred_gap_left == '0) begin
                     pred_compare = '0;
                     pred_phase = PH_IDLE;
                     done = 1'b1;
                  end
               end
            end
         end
      end
      r.pin_level = (pred_count < pred_compare);
      r.playing   = (pred_phase != PH_IDLE);
      r.note_done = done;
      return r;
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR: %s", msg);
      error_count++;
   endtask

   // Track accepted words, check results and follow register writes
   always @(posedge clock) begin
      if (reset) begin
         cfg_tick_rate = TICK_RATE_RESET;
         cfg_tpms      = TPMS_RESET;
         cfg_gap       = GAP_RESET;
         cfg_gap_min   = GAP_MIN_RESET;
         pred_period   = '0;
         pred_compare  = '0;
         pred_count    = '0;
         pred_prescale = '0;
         pred_ms_left  = '0;
         pred_gap_left = '0;
         pred_phase    = PH_IDLE;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = advance_player(req_data);
            expected_words.push_back(row_typed ? row_want : predicted);
            words_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_data.note_done) notes_ended++;
            if (expected_words.size() == 0) begin
               report_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want_w = expected_words.pop_front();
               if (rsp_data.pin_level !== want_w.pin_level)
                  report_error($sformatf("result %0d pin_level got %b want %b", results_seen,
                                         rsp_data.pin_level, want_w.pin_level));
               if (rsp_data.playing !== want_w.playing)
                  report_error($sformatf("result %0d playing got %b want %b", results_seen,
                                         rsp_data.playing, want_w.playing));
               if (rsp_data.note_done !== want_w.note_done)
                  report_error($sformatf("result %0d note_done got %b want %b", results_seen,
                                         rsp_data.note_done, want_w.note_done));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TICK_RATE: cfg_tick_rate = csr_data[TICK_RATE_BITS-1:0];
               CSR_TPMS:      cfg_tpms      = csr_data[TPMS_BITS-1:0];
               CSR_GAP:       cfg_gap       = csr_data[GAP_BITS-1:0];
               CSR_GAP_MIN:   cfg_gap_min   = csr_data[DUR_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold on request
   always @(negedge clock) begin
      if (hold_rsp_request) begin
         hold_rsp_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one word, maybe after an idle burst, and hold it until accepted
   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type want);
      int gap_cycles;
      gap_cycles = 0;
      if (req_idle_en && $urandom_range(0, 7) == 0) gap_cycles = $urandom_range(1, 11);
      @(negedge clock);
      if (gap_cycles > 0) begin
         req_valid <= 1'b0;
         repeat (gap_cycles) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      row_typed = typed;
      row_want  = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                   input logic [CSR_DATA_BITS-1:0] val);
      stim_row_type r;
      r = '{default: '0};
      r.is_reg    = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_word(input logic cmd, input int freq, input int dur,
                                    input int reps, input bit typed, input rsp_word_type want);
      stim_row_type r;
      r = '{default: '0};
      r.word.cmd     = cmd;
      r.word.tone_hz = freq[FREQ_BITS-1:0];
      r.word.note_ms = dur[DUR_BITS-1:0];
      r.repeats      = reps;
      r.typed        = typed;
      r.want         = want;
      directed_rows.push_back(r);
   endfunction

   // Stimulus: directed table, then random phases under several settings
   initial begin
      int                        phase;
      int                        sent;
      int                        n_ticks;
      int                        k;
      bit                        paused;
      logic [TICK_RATE_BITS-1:0] f_calc;
      logic [TICK_RATE_BITS-1:0] new_rate;
      logic [TPMS_BITS-1:0]      new_tpms;
      logic [GAP_BITS-1:0]       new_gap;
      logic [DUR_BITS-1:0]       new_gap_min;
      req_word_type              w;

      paused = 1'b0;

      // Directed table under reset values first
      add_word(CMD_TICK, 0, 0, 1, 1'b1, 3'b000);
      add_word(CMD_LOAD, 0, 0, 1, 1'b1, 3'b001);
      add_word(CMD_LOAD, 65535, 0, 1, 1'b1, 3'b001);
      add_word(CMD_LOAD, 1, 3, 1, 1'b1, 3'b110);
      add_word(CMD_LOAD, 65535, 65535, 1, 1'b0, '0);
      // Gap longer than the note goes straight to silence
      add_reg(CSR_TPMS, 24'd1);
      add_reg(CSR_GAP, 24'd255);
      add_reg(CSR_GAP_MIN, 24'd0);
      add_word(CMD_LOAD, 500, 10, 1, 1'b1, 3'b010);
      // Short note with a gap, run to its end
      add_reg(CSR_GAP, 24'd3);
      add_word(CMD_LOAD, 500, 5, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 5, 1'b0, '0);
      // Quotient below the minimum period
      add_reg(CSR_TICK_RATE, 24'd0);
      add_word(CMD_LOAD, 7, 2, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 1, 1'b0, '0);
      // Quotient above the maximum period, then load over a running note
      add_reg(CSR_TICK_RATE, 24'hFFFFFF);
      add_word(CMD_LOAD, 1, 4, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 1, 1'b0, '0);
      add_word(CMD_LOAD, 2000, 2, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 2, 1'b0, '0);
      // Unknown register index, then a rest with a duration
      add_reg(CSR_INDEX_BITS'(200), 24'h5A5A5A);
      add_word(CMD_LOAD, 0, 3, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 3, 1'b0, '0);
      // Zero ticks per millisecond acts as one
      add_reg(CSR_TPMS, 24'd0);
      add_word(CMD_LOAD, 3, 1, 1, 1'b0, '0);
      add_word(CMD_TICK, 0, 0, 1, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_reg) begin
            wait_drain();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            repeat (directed_rows[i].repeats)
               send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drain();
         // Pick this phase's setting: fixed extremes first, then random
         case (phase)
            0: begin
               new_rate = 24'd1000000; new_tpms = 16'd1; new_gap = 8'd2; new_gap_min = 16'd3;
            end
            1: begin
               new_rate = 24'hFFFFFF; new_tpms = 16'd2; new_gap = 8'hFF; new_gap_min = 16'd0;
            end
            2: begin
               new_rate = 24'd1; new_tpms = 16'hFFFF; new_gap = 8'd0; new_gap_min = 16'hFFFF;
            end
            default: begin
               new_rate    = TICK_RATE_BITS'($urandom_range(1, 24'hFFFFFF));
               new_tpms    = TPMS_BITS'($urandom_range(1, 6));
               new_gap     = GAP_BITS'($urandom_range(0, 6));
               new_gap_min = DUR_BITS'($urandom_range(0, 12));
            end
         endcase
         // Upper bits beyond each register's width are junk and must be dropped
         write_reg(CSR_TICK_RATE, new_rate);
         write_reg(CSR_TPMS, {8'($urandom), new_tpms});
         write_reg(CSR_GAP, {16'($urandom), new_gap});
         write_reg(CSR_GAP_MIN, {8'($urandom), new_gap_min});
         write_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), CSR_DATA_BITS'($urandom));

         if (phase == PHASES - 1) begin
            req_idle_en = 1'b0;
            rsp_idle_en = 1'b0;
         end

         // Hold the receiver off while ticks keep coming, to back up the input
         if (phase == 3) begin
            hold_rsp_request = 1'b1;
            req_idle_en = 1'b0;
            repeat (HOLD_WORDS) begin
               w.cmd     = CMD_TICK;
               w.tone_hz = FREQ_BITS'($urandom);
               w.note_ms = DUR_BITS'($urandom);
               send_word(w, 1'b0, '0);
            end
            req_idle_en = 1'b1;
         end

         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            if (phase == 5 && !paused && sent >= WORDS_PER_PHASE / 2) begin
               paused = 1'b1;
               wait_drain();
            end
            if ($urandom_range(0, 9) == 0) begin
               // Noise word with every field random
               w.cmd     = 1'($urandom_range(0, 1));
               w.tone_hz = FREQ_BITS'($urandom);
               w.note_ms = DUR_BITS'($urandom);
               send_word(w, 1'b0, '0);
               sent++;
            end else begin
               // Note load followed by a run of ticks
               w.cmd = CMD_LOAD;
               case ($urandom_range(0, 9))
                  0:       w.tone_hz = '0;
                  1, 2:    w.tone_hz = FREQ_BITS'($urandom);
                  default: begin
                     k = $urandom_range(2, 40);
                     f_calc = cfg_tick_rate / k;
                     if (f_calc == '0) begin
                        w.tone_hz = 16'd1;
                     end else if (f_calc > 24'hFFFF) begin
                        w.tone_hz = 16'hFFFF;
                     end else begin
                        w.tone_hz = f_calc[FREQ_BITS-1:0];
                     end
                  end
               endcase
               if ($urandom_range(0, 4) == 0) begin
                  w.note_ms = DUR_BITS'($urandom);
               end else begin
                  w.note_ms = DUR_BITS'($urandom_range(0, 12));
               end
               send_word(w, 1'b0, '0);
               sent++;
               n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120)
                                                     : $urandom_range(0, 30);
               repeat (n_ticks) begin
                  w.cmd     = CMD_TICK;
                  w.tone_hz = FREQ_BITS'($urandom);
                  w.note_ms = DUR_BITS'($urandom);
                  send_word(w, 1'b0, '0);
                  sent++;
               end
            end
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d words over the directed table and %0d register phases,",
               words_accepted, PHASES);
      $display("%0d results compared, %0d of them ending a note.", results_seen, notes_ended);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bnt_pkg.sv
src/bnt_front.sv
src/bnt_divider.sv
src/bnt_back.sv
src/buzzer_note_tone_player.sv
bench/buzzer_note_tone_player_tb.sv
